[hw/rtl/tpwa_pkg.sv]
// Shared widths and constants of the temporal pixel weighted average unit.
`timescale 1ns / 1ps
`default_nettype none

package tpwa_pkg;

  localparam int unsigned ROW_W        = 6;
  localparam int unsigned COL_W        = 6;
  localparam int unsigned SLOT_W       = 2;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEFF_W      = 17;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 16;

  localparam logic [COEFF_W-1:0] COEFF_ONE   = 17'h10000;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 17'h08000;

  localparam int unsigned TD_ROW_LO    = 0;
  localparam int unsigned TD_COL_LO    = TD_ROW_LO + ROW_W;
  localparam int unsigned TD_SLOT_LO   = TD_COL_LO + COL_W;
  localparam int unsigned TD_SAMPLE_LO = TD_SLOT_LO + SLOT_W;

  localparam int unsigned PROD_W = SAMPLE_W + COEFF_W;

endpackage

`default_nettype wire

[hw/rtl/tpwa_recip_div.sv]
// Two-stage divide of the weighted sum by 2^k-1 through a reciprocal table.
`timescale 1ns / 1ps
`default_nettype none

module tpwa_recip_div #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        en_i,
  input  wire logic                                        valid_i,
  input  wire logic [tpwa_pkg::SAMPLE_W+QUEUE_DEPTH-1:0]   sum_i,
  input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]            k_i,
  output logic                                             valid_o,
  output logic [tpwa_pkg::SAMPLE_W-1:0]                    quot_o
);
  import tpwa_pkg::*;

  localparam int unsigned SW = SAMPLE_W + QUEUE_DEPTH;
  localparam int unsigned KW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned RW = SW + QUEUE_DEPTH + 1;

  logic [SW:0] recip_tab [QUEUE_DEPTH+1];

  assign recip_tab[0] = '0;
  for (genvar g = 1; g <= QUEUE_DEPTH; g++) begin : g_recip
    localparam logic [SW:0] RECIP = (SW+1)'((64'd1 << SW) / ((64'd1 << g) - 64'd1));
    assign recip_tab[g] = RECIP;
  end

  logic              va_q;
  logic [SW-1:0]     suma_q;
  logic [KW-1:0]     ka_q;
  logic              vb_q;
  logic [2*SW:0]     prodb_q;
  logic [SW-1:0]     sumb_q;
  logic [KW-1:0]     kb_q;

  logic [2*SW:0]     prod_d;
  logic [SW-1:0]     q0;
  logic [RW-1:0]     qd;
  logic [RW-1:0]     rem;
  logic [RW-1:0]     divisor;
  logic [SW-1:0]     quot;

  assign prod_d = (2*SW+1)'(suma_q) * (2*SW+1)'(recip_tab[ka_q]);

  always_comb begin
    q0      = prodb_q[2*SW-1:SW];
    qd      = (RW'(q0) << kb_q) - RW'(q0);
    rem     = RW'(sumb_q) - qd;
    divisor = (RW'(1) << kb_q) - RW'(1);
    quot    = (rem >= divisor) ? q0 + SW'(1) : q0;
  end

  assign valid_o = vb_q;
  assign quot_o  = quot[SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      suma_q  <= sum_i;
      ka_q    <= k_i;
      prodb_q <= prod_d;
      sumb_q  <= suma_q;
      kb_q    <= ka_q;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/temporal_pixel_weighted_average_unit.sv]
// Top level of the temporal pixel weighted average filter.
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | s_axis_tvalid/tready   | tdata: row, column, slot_index, sample
//           |           |                        | tuser: queue_full
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: filtered_value
//  cfg      | in        | cfg_valid_i/cfg_ready_o| blend_coeff, always ready
//
// One beat per cycle unless a pixel hazard or output back-pressure holds the input.
// The pixel queue memory has one read and one write port; a beat whose pixel
// matches a beat in stages 1, 2 or 3 waits until that beat has been written.
// The queue memory has no reset; the coefficient resets to one half.
// An unaccepted output beat freezes the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

module temporal_pixel_weighted_average_unit #(
  parameter int unsigned ROWS        = 64,
  parameter int unsigned COLS        = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // row[5:0], column[11:6], slot_index[13:12], sample[29:14], zero[31:30]
  input  wire logic [tpwa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // queue_full[0]
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // filtered_value[15:0]
  output logic [tpwa_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [tpwa_pkg::COEFF_W-1:0]        cfg_data_i
);
  import tpwa_pkg::*;

  localparam int unsigned PIXELS = ROWS * COLS;
  localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned RMW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CMW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned SLW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned SW     = SAMPLE_W + QUEUE_DEPTH;
  localparam int unsigned KW     = $clog2(QUEUE_DEPTH + 1);

  typedef logic [QUEUE_DEPTH-1:0][SAMPLE_W-1:0] word_t;

  logic [RMW-1:0] row_tab [2**ROW_W];
  logic [CMW-1:0] col_tab [2**COL_W];

  for (genvar g = 0; g < 2**ROW_W; g++) begin : g_row
    localparam int unsigned RM = g % ROWS;
    assign row_tab[g] = RMW'(RM);
  end
  for (genvar g = 0; g < 2**COL_W; g++) begin : g_col
    localparam int unsigned CM = g % COLS;
    assign col_tab[g] = CMW'(CM);
  end

  word_t mem [PIXELS];

  logic [COEFF_W-1:0] coeff_q;

  logic                en;
  logic                hazard;
  logic                accept;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic [SLOT_W-1:0]   in_slot;
  logic [SLW-1:0]      in_slot_sat;
  logic [AW-1:0]       in_pix;

  logic                v1_q, v2_q, v3_q;
  logic [AW-1:0]       pix1_q, pix2_q, pix3_q;
  logic [SLW-1:0]      slot1_q, slot2_q, slot3_q;
  logic                full1_q, full2_q, full3_q;
  logic [SAMPLE_W-1:0] smp1_q, smp2_q;
  word_t               rd_q, word2_q, word3_q, store3_q;
  logic [PROD_W-1:0]   pnew2_q, pold2_q;

  logic [COEFF_W-1:0]  coeff_eff;
  logic [SLW-1:0]      prev_idx;
  logic [SAMPLE_W-1:0] prev;
  logic [PROD_W-1:0]   pnew_d, pold_d;

  logic [PROD_W-1:0]   mix;
  logic [SAMPLE_W-1:0] new_smp;
  word_t               word_new;
  word_t               word_store;

  logic [SW-1:0]       wsum;
  logic [KW-1:0]       k3;

  logic                div_valid;
  logic [SAMPLE_W-1:0] div_quot;

  assign in_row  = s_axis_tdata[TD_COL_LO-1:TD_ROW_LO];
  assign in_col  = s_axis_tdata[TD_SLOT_LO-1:TD_COL_LO];
  assign in_slot = s_axis_tdata[TD_SAMPLE_LO-1:TD_SLOT_LO];

  always_comb begin
    if (32'(in_slot) >= QUEUE_DEPTH) begin
      in_slot_sat = SLW'(QUEUE_DEPTH - 1);
    end else begin
      in_slot_sat = SLW'(in_slot);
    end
    in_pix = AW'(AW'(row_tab[in_row]) * AW'(COLS) + AW'(col_tab[in_col]));
  end

  assign en     = !m_axis_tvalid || m_axis_tready;
  assign hazard = (v1_q && pix1_q == in_pix) || (v2_q && pix2_q == in_pix)
                  || (v3_q && pix3_q == in_pix);
  assign s_axis_tready = en && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= COEFF_RESET;
    end else if (cfg_valid_i) begin
      coeff_q <= cfg_data_i;
    end
  end

  // Stage 1: memory word is here, form both blend products.
  always_comb begin
    coeff_eff = coeff_q[COEFF_W-1] ? COEFF_ONE : coeff_q;
    prev_idx  = (slot1_q == '0) ? '0 : slot1_q - SLW'(1);
    prev      = (slot1_q == '0) ? '0 : rd_q[prev_idx];
    pnew_d    = PROD_W'(smp1_q) * PROD_W'(coeff_eff);
    pold_d    = PROD_W'(prev) * PROD_W'(COEFF_ONE - coeff_eff);
  end

  // Stage 2: finish the blend, build the new and the stored queue word.
  always_comb begin
    mix     = pnew2_q + pold2_q;
    new_smp = (slot2_q == '0) ? smp2_q : mix[SAMPLE_W+15:16];
    word_new = word2_q;
    word_new[slot2_q] = new_smp;
    word_store = word_new;
    if (32'(slot2_q) == QUEUE_DEPTH - 1) begin
      for (int z = 0; z + 1 < QUEUE_DEPTH; z++) begin
        word_store[z] = word_new[z + 1];
      end
    end
  end

  // Stage 3: weighted sum and divisor exponent.
  always_comb begin
    wsum = '0;
    for (int z = 0; z < QUEUE_DEPTH; z++) begin
      if (z <= 32'(slot3_q)) begin
        wsum = wsum + (SW'(word3_q[z]) << z);
      end
    end
    k3 = full3_q ? KW'(QUEUE_DEPTH) : KW'(slot3_q) + KW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q    <= mem[in_pix];
      pix1_q  <= in_pix;
      slot1_q <= in_slot_sat;
      full1_q <= s_axis_tuser;
      smp1_q  <= s_axis_tdata[TD_SAMPLE_LO+SAMPLE_W-1:TD_SAMPLE_LO];

      pix2_q  <= pix1_q;
      slot2_q <= slot1_q;
      full2_q <= full1_q;
      smp2_q  <= smp1_q;
      word2_q <= rd_q;
      pnew2_q <= pnew_d;
      pold2_q <= pold_d;

      pix3_q   <= pix2_q;
      slot3_q  <= slot2_q;
      full3_q  <= full2_q;
      word3_q  <= word_new;
      store3_q <= word_store;

      if (v3_q) begin
        mem[pix3_q] <= store3_q;
      end
    end
  end

  tpwa_recip_div #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .sum_i   (wsum),
    .k_i     (k3),
    .valid_o (div_valid),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && div_valid) begin
      m_axis_tdata <= OUT_TDATA_W'(div_quot);
    end
  end

endmodule

`default_nettype wire

[tb/sv/temporal_pixel_weighted_average_unit_tb.sv]
// Self-checking testbench of the temporal pixel weighted average unit.
`timescale 1ns / 1ps

module temporal_pixel_weighted_average_unit_tb;

  localparam int unsigned ROWS        = 64;
  localparam int unsigned COLS        = 64;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned PIXELS      = ROWS * COLS;
  localparam int unsigned FULL_DIV    = (1 << QDEPTH) - 1;
  localparam int unsigned HOT_N       = 12;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_SPARSE} pace_e;

  class pixel_average_tracker;
    logic [tpwa_pkg::SAMPLE_W-1:0] slot_plane [QDEPTH][PIXELS];
    logic [tpwa_pkg::COEFF_W-1:0]  coeff;
    logic [15:0]                   expected_avg [$];
    int unsigned                   mismatches;

    function new();
      coeff      = tpwa_pkg::COEFF_RESET;
      mismatches = 0;
    endfunction

    function void set_coeff(logic [tpwa_pkg::COEFF_W-1:0] value);
      coeff = value;
    endfunction

    function int unsigned pending();
      return expected_avg.size();
    endfunction

    function void take_sample(logic [5:0] row, logic [5:0] col, logic [1:0] slot,
                              logic [15:0] smp, logic full);
      int unsigned                  pix;
      int unsigned                  z;
      logic [tpwa_pkg::COEFF_W-1:0] weight;
      logic [33:0]                  mix;
      logic [19:0]                  acc;
      logic [19:0]                  divisor;
      logic [15:0]                  value;
      pix    = {row, col};
      weight = (coeff > tpwa_pkg::COEFF_ONE) ? tpwa_pkg::COEFF_ONE : coeff;
      value  = smp;
      if (slot != 0) begin
        mix   = 34'(smp) * 34'(weight)
              + 34'(slot_plane[slot - 1][pix]) * 34'(tpwa_pkg::COEFF_ONE - weight);
        value = mix[31:16];
      end
      slot_plane[slot][pix] = value;
      acc = '0;
      for (z = 0; z <= slot; z++) begin
        acc += 20'(slot_plane[z][pix]) << z;
      end
      divisor = full ? 20'(FULL_DIV) : 20'((1 << (slot + 1)) - 1);
      acc = acc / divisor;
      expected_avg.push_back(acc[15:0]);
      if (slot == QDEPTH - 1) begin
        for (z = 0; z + 1 < QDEPTH; z++) begin
          slot_plane[z][pix] = slot_plane[z + 1][pix];
        end
      end
    endfunction

    function void check_average(logic [15:0] got);
      logic [15:0] want;
      if (expected_avg.size() == 0) begin
        $display("%0t: unexpected filtered_value, expected none, actual %0d", $time, got);
        mismatches++;
      end else begin
        want = expected_avg.pop_front();
        if (got !== want) begin
          $display("%0t: filtered_value mismatch, expected %0d, actual %0d",
                   $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                               clk           = 1'b0;
  logic                               rst_n         = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [tpwa_pkg::IN_TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                               s_axis_tuser  = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [tpwa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                               cfg_valid     = 1'b0;
  logic                               cfg_ready;
  logic [tpwa_pkg::COEFF_W-1:0]       cfg_data      = '0;

  pixel_average_tracker tracker = new();

  byte unsigned depth_filled [PIXELS];
  int unsigned  hot_pix [HOT_N];
  pace_e        feed_mode = PACE_RANDOM;
  pace_e        sink_mode = PACE_RANDOM;
  bit           long_hold = 1'b0;

  temporal_pixel_weighted_average_unit #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned draw_wait(pace_e mode);
    case (mode)
      PACE_STEADY: return 0;
      PACE_RANDOM: return $urandom_range(0, 18);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  task automatic send_sample(input logic [5:0] row, input logic [5:0] col,
                             input logic [1:0] slot, input logic [15:0] smp,
                             input logic full);
    int unsigned gap;
    int unsigned pix;
    gap = draw_wait(feed_mode);
    pix = {row, col};
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, smp, slot, col, row};
    s_axis_tuser  <= full;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_sample(row, col, slot, smp, full);
    if (slot == depth_filled[pix]) begin
      depth_filled[pix]++;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_coeff(input logic [tpwa_pkg::COEFF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_coeff(value);
  endtask

  task automatic run_phase(input int unsigned count, input pace_e feed, input pace_e sink,
                           input bit hold);
    int unsigned pix;
    int unsigned lim;
    logic [1:0]  slot;
    logic [15:0] smp;
    logic        full;
    feed_mode = feed;
    sink_mode = sink;
    for (int unsigned k = 0; k < count; k++) begin
      // flood the input while the sink backs off
      if (hold && k == count / 2) begin
        feed_mode = PACE_STEADY;
        long_hold = 1'b1;
      end
      pix  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, PIXELS - 1)
                                         : hot_pix[$urandom_range(0, HOT_N - 1)];
      lim  = (depth_filled[pix] > QDEPTH - 1) ? QDEPTH - 1 : depth_filled[pix];
      slot = ($urandom_range(0, 4) != 0) ? lim : $urandom_range(0, lim);
      case ($urandom_range(0, 9))
        0:       smp = '0;
        1:       smp = '1;
        default: smp = 16'($urandom_range(0, 65535));
      endcase
      full = (slot == QDEPTH - 1) ^ ($urandom_range(0, 7) == 0);
      send_sample(6'(pix / COLS), 6'(pix % COLS), slot, smp, full);
    end
    drain_results();
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    forever begin
      if (long_hold) begin
        stall     = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        stall = draw_wait(sink_mode);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      tracker.check_average(m_axis_tdata);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("temporal_pixel_weighted_average_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [tpwa_pkg::COEFF_W-1:0] coeff_plan [PHASES];
    hot_pix[0] = 0;
    hot_pix[1] = PIXELS - 1;
    for (int i = 2; i < HOT_N; i++) begin
      hot_pix[i] = $urandom_range(0, PIXELS - 1);
    end
    coeff_plan[0] = 17'd0;
    coeff_plan[1] = tpwa_pkg::COEFF_ONE;
    coeff_plan[2] = 17'h1FFFF;
    coeff_plan[3] = tpwa_pkg::COEFF_ONE + 17'd1;
    coeff_plan[4] = 17'd1;
    coeff_plan[5] = 17'd65535;
    coeff_plan[6] = 17'($urandom_range(0, 65536));
    coeff_plan[7] = 17'($urandom_range(65537, 131071));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weight of one half, every slot, shift and early full divisor
    send_sample(0, 0, 0, 16'hFFFF, 1'b0);
    send_sample(0, 0, 1, 16'hFFFF, 1'b0);
    send_sample(0, 0, 2, 16'h0000, 1'b0);
    send_sample(0, 0, 3, 16'hFFFF, 1'b1);
    send_sample(0, 0, 3, 16'h0000, 1'b0);
    send_sample(0, 0, 0, 16'h1234, 1'b1);
    send_sample(63, 63, 0, 16'h0000, 1'b0);
    send_sample(63, 63, 1, 16'hFFFF, 1'b1);
    send_sample(63, 63, 2, 16'hFFFF, 1'b0);
    send_sample(63, 63, 3, 16'h0000, 1'b1);
    send_sample(63, 0, 0, 16'hAAAA, 1'b0);
    send_sample(0, 63, 0, 16'h5555, 1'b1);
    send_sample(0, 63, 1, 16'hAAAA, 1'b0);
    drain_results();

    // weight beyond one saturates
    write_coeff(17'h1FFFF);
    send_sample(0, 0, 1, 16'h0000, 1'b0);
    send_sample(0, 0, 2, 16'hFFFF, 1'b1);
    send_sample(63, 63, 3, 16'h8001, 1'b1);
    drain_results();

    // zero weight keeps the previous slot
    write_coeff(17'd0);
    send_sample(63, 0, 1, 16'hFFFF, 1'b0);
    send_sample(0, 63, 2, 16'h0000, 1'b0);
    send_sample(0, 63, 3, 16'hFFFF, 1'b1);
    send_sample(0, 0, 3, 16'h7FFF, 1'b0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_coeff(coeff_plan[p]);
      run_phase(PHASE_ITEMS, pace_e'(p % 3), pace_e'((p + 1) % 3), p == 1 || p == 5);
    end

    while (tracker.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("temporal_pixel_weighted_average_unit verification clean");
    end else begin
      $display("temporal_pixel_weighted_average_unit verification failed");
    end
    $finish;
  end

endmodule
